FILE: rtl/kvla_pkg.sv
// shared types and constants for the key/value line to arena parser
`timescale 1ns / 1ps

package kvla_pkg;

   // arena geometry
   localparam int WORD_BYTES      = 4;
   localparam int MAX_ARENA_WORDS = 1024;
   localparam int ADDR_W          = 12;
   localparam int DATA_W          = 12;
   localparam int CFG_W           = 11;
   localparam int LIMIT_W         = 13;
   localparam int SSW_W           = 10;
   localparam int LANE_W          = 3;
   localparam int WB_SHIFT        = 2;

   // result queue sizing
   localparam int MAX_RESULTS = 16;
   localparam int RSPQ_DEPTH  = 32;
   localparam int RSPQ_PTR_W  = 5;

   // opcodes
   localparam logic [1:0] OP_DATA   = 2'd0;
   localparam logic [1:0] OP_END    = 2'd1;
   localparam logic [1:0] OP_START  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ILLEGAL = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   // characters
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;

   typedef enum logic [6:0] {
      PS_START     = 7'b0000001,
      PS_BLANK_KEY = 7'b0000010,
      PS_KEY       = 7'b0000100,
      PS_BLANK_VAL = 7'b0001000,
      PS_QUOTED    = 7'b0010000,
      PS_PLAIN     = 7'b0100000,
      PS_ESC       = 7'b1000000
   } parse_state_type;

   typedef enum logic [4:0] {
      EX_IDLE   = 5'b00001,
      EX_APPEND = 5'b00010,
      EX_PAD    = 5'b00100,
      EX_WORD   = 5'b01000,
      EX_END    = 5'b10000
   } exec_state_type;

   // classified input item
   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] char_byte;
      logic       is_tok;
      logic       is_nl;
      logic       is_blank;
      logic       is_eq;
      logic       is_quote;
      logic       is_bslash;
      logic       esc_ok;
      logic [7:0] esc_char;
   } item_type;

   typedef struct packed {
      logic              write_valid;
      logic              write_is_word;
      logic [ADDR_W-1:0] write_addr;
      logic [DATA_W-1:0] write_data;
      logic              last;
   } result_type;

   typedef struct packed {
      logic [1:0] status;
      logic       finished;
   } item_stat_type;

endpackage

FILE: rtl/kvla_front.sv
// front end: input queue that accepts and classifies command bytes
`timescale 1ns / 1ps

module kvla_front import kvla_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_char_byte,
   output logic       req_full,
   output item_type   item,
   output logic       item_valid,
   input  logic       item_take
);

   function automatic item_type classify(input logic [1:0] op, input logic [7:0] c);
      item_type r;
      r.opcode    = op;
      r.char_byte = c;
      r.is_tok    = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                    (c >= 8'h30 && c <= 8'h39) || (c == CH_DASH);
      r.is_nl     = (c == CH_LF) || (c == CH_CR);
      r.is_blank  = r.is_nl || (c == CH_SPACE) || (c == CH_TAB);
      r.is_eq     = (c == CH_EQ);
      r.is_quote  = (c == CH_QUOTE);
      r.is_bslash = (c == CH_BSLASH);
      r.esc_ok    = 1'b1;
      case (c)
         CH_N:               r.esc_char = CH_LF;
         CH_R:               r.esc_char = CH_CR;
         CH_T:               r.esc_char = CH_TAB;
         CH_BSLASH, CH_QUOTE: r.esc_char = c;
         default: begin
            r.esc_char = c;
            r.esc_ok   = 1'b0;
         end
      endcase
      return r;
   endfunction

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok, take_ok;

   // two-entry queue
   assign req_full   = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;
   assign take_ok    = item_take && item_valid;

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, take_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= classify(req_opcode, req_char_byte);
      end
   end

endmodule

FILE: rtl/kvla_exec.sv
// back end: parse sequencer that issues arena writes one per cycle
`timescale 1ns / 1ps

module kvla_exec import kvla_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  item_type         item,
   input  logic             item_valid,
   output logic             item_take,
   input  logic             room,
   input  logic [CFG_W-1:0] arena_words,
   output logic             res_push,
   output result_type       res_data,
   output logic             stat_push,
   output item_stat_type    stat_data
);

   exec_state_type    ex_state_ff, ex_state_in;
   parse_state_type   ps_ff, ps_in;
   logic [ADDR_W-1:0] cursor_ff, cursor_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [SSW_W-1:0]  ssw_ff, ssw_in;
   logic [LANE_W-1:0] lane_ff, lane_in;
   logic              nonempty_ff, nonempty_in;
   logic              finished_ff, finished_in;
   logic [1:0]        err_ff, err_in;
   logic [1:0]        closes_ff, closes_in;
   logic [7:0]        val_ff, val_in;
   logic              fin_pend_ff, fin_pend_in;
   result_type        pend_ff, pend_in;
   logic              have_pend_ff, have_pend_in;

   // plan for one item
   logic              p_err, p_append, p_fin_always, p_fin_ok;
   logic [7:0]        p_val;
   logic [1:0]        p_closes;
   parse_state_type   p_state;

   // cursor arithmetic
   logic [LIMIT_W-1:0] cur_p1, cur_p4, limit_start;
   logic               byte_full, word_full;
   logic [LANE_W-1:0]  lane_nx;
   logic [CFG_W-1:0]   words_clamped;
   logic [ADDR_W-1:0]  base_addr;
   logic               emit_en;
   result_type         emit_r;
   logic               fin_final;

   assign cur_p1    = {1'b0, cursor_ff} + LIMIT_W'(1);
   assign cur_p4    = {1'b0, cursor_ff} + LIMIT_W'(WORD_BYTES);
   assign byte_full = (cur_p1 >= limit_ff);
   assign word_full = (cur_p4 >= limit_ff);
   assign lane_nx   = (lane_ff == LANE_W'(WORD_BYTES)) ? LANE_W'(1) : lane_ff + LANE_W'(1);
   assign base_addr = {ssw_ff, 2'b00};
   assign fin_final = finished_ff || (fin_pend_ff && (err_ff == ST_OK));

   // arena size taken at start, clamped to 1..max
   always_comb begin
      words_clamped = arena_words;
      if (arena_words == '0) begin
         words_clamped = CFG_W'(1);
      end else if (arena_words > CFG_W'(MAX_ARENA_WORDS)) begin
         words_clamped = CFG_W'(MAX_ARENA_WORDS);
      end
      limit_start = {words_clamped, 2'b00};
   end

   // decode the item against the parse state
   always_comb begin
      p_err        = 1'b0;
      p_append     = 1'b0;
      p_val        = item.char_byte;
      p_closes     = 2'd0;
      p_state      = ps_ff;
      p_fin_always = 1'b0;
      p_fin_ok     = 1'b0;
      if (item.opcode == OP_END) begin
         p_fin_always = 1'b1;
         unique case (ps_ff)
            PS_START, PS_BLANK_KEY: p_closes = 2'd1;
            PS_KEY:                 p_closes = 2'd3;
            PS_BLANK_VAL, PS_PLAIN: p_closes = 2'd2;
            default:                p_err    = 1'b1;
         endcase
      end else begin
         unique case (ps_ff)
            PS_START: begin
               if (item.is_nl) begin
               end else if (item.is_blank) begin
                  p_state = PS_BLANK_KEY;
               end else if (item.is_tok) begin
                  p_state  = PS_KEY;
                  p_append = 1'b1;
               end else begin
                  p_err = 1'b1;
               end
            end
            PS_BLANK_KEY: begin
               if (item.is_nl) begin
                  p_closes     = 2'd1;
                  p_fin_always = 1'b1;
               end else if (item.is_blank) begin
               end else if (item.is_tok) begin
                  p_state  = PS_KEY;
                  p_append = 1'b1;
               end else begin
                  p_err = 1'b1;
               end
            end
            PS_KEY: begin
               if (item.is_nl) begin
                  p_closes = 2'd3;
                  p_fin_ok = 1'b1;
               end else if (item.is_tok) begin
                  p_append = 1'b1;
               end else if (item.is_blank) begin
                  p_closes = 2'd2;
                  p_state  = PS_BLANK_KEY;
               end else if (item.is_eq) begin
                  p_closes = 2'd1;
                  p_state  = PS_BLANK_VAL;
               end else begin
                  p_err = 1'b1;
               end
            end
            PS_BLANK_VAL: begin
               if (item.is_blank && !item.is_nl) begin
               end else if (item.is_tok) begin
                  p_append = 1'b1;
                  p_state  = PS_PLAIN;
               end else if (item.is_quote) begin
                  p_state = PS_QUOTED;
               end else begin
                  p_err = 1'b1;
               end
            end
            PS_QUOTED: begin
               if (item.is_quote) begin
                  p_closes = 2'd1;
                  p_state  = PS_BLANK_KEY;
               end else if (item.is_bslash) begin
                  p_state = PS_ESC;
               end else if (item.is_nl) begin
                  p_err = 1'b1;
               end else begin
                  p_append = 1'b1;
               end
            end
            PS_PLAIN: begin
               if (item.is_tok) begin
                  p_append = 1'b1;
               end else if (item.is_nl) begin
                  p_closes = 2'd2;
                  p_fin_ok = 1'b1;
               end else if (item.is_blank) begin
                  p_closes = 2'd1;
                  p_state  = PS_BLANK_KEY;
               end else begin
                  p_err = 1'b1;
               end
            end
            default: begin
               p_state  = PS_QUOTED;
               p_val    = item.esc_char;
               p_append = item.esc_ok;
               p_err    = !item.esc_ok;
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      ex_state_in  = ex_state_ff;
      ps_in        = ps_ff;
      cursor_in    = cursor_ff;
      limit_in     = limit_ff;
      ssw_in       = ssw_ff;
      lane_in      = lane_ff;
      nonempty_in  = nonempty_ff;
      finished_in  = finished_ff;
      err_in       = err_ff;
      closes_in    = closes_ff;
      val_in       = val_ff;
      fin_pend_in  = fin_pend_ff;
      pend_in      = pend_ff;
      have_pend_in = have_pend_ff;
      item_take    = 1'b0;
      res_push     = 1'b0;
      res_data     = '0;
      stat_push    = 1'b0;
      stat_data    = '0;
      emit_en      = 1'b0;
      emit_r       = '0;

      unique case (ex_state_ff)
         EX_IDLE: begin
            if (item_valid && room) begin
               item_take   = 1'b1;
               ex_state_in = EX_END;
               if (item.opcode == OP_START) begin
                  limit_in    = limit_start;
                  ssw_in      = '0;
                  lane_in     = LANE_W'(1);
                  nonempty_in = 1'b0;
                  ps_in       = PS_START;
                  finished_in = 1'b0;
                  fin_pend_in = 1'b0;
                  if (limit_start <= LIMIT_W'(WORD_BYTES)) begin
                     err_in    = ST_FULL;
                     cursor_in = ADDR_W'(limit_start - LIMIT_W'(1));
                  end else begin
                     err_in    = ST_OK;
                     cursor_in = ADDR_W'(WORD_BYTES);
                  end
               end else if ((item.opcode == OP_DATA || item.opcode == OP_END) &&
                            !finished_ff && (err_ff == ST_OK)) begin
                  ps_in       = p_state;
                  fin_pend_in = p_fin_ok;
                  closes_in   = p_closes;
                  val_in      = p_val;
                  if (p_fin_always) begin
                     finished_in = 1'b1;
                  end
                  if (p_err) begin
                     err_in = ST_ILLEGAL;
                  end else if (p_append) begin
                     ex_state_in = EX_APPEND;
                  end else if (p_closes != 2'd0) begin
                     ex_state_in = nonempty_ff ? EX_PAD : EX_WORD;
                  end
               end
            end
         end
         EX_APPEND: begin
            emit_en     = 1'b1;
            emit_r      = '{write_valid: 1'b1, write_is_word: 1'b0, write_addr: cursor_ff,
                            write_data: {4'b0, val_ff}, last: 1'b0};
            nonempty_in = 1'b1;
            if (byte_full) begin
               err_in      = ST_FULL;
               ex_state_in = EX_END;
            end else begin
               cursor_in   = cur_p1[ADDR_W-1:0];
               lane_in     = lane_nx;
               ex_state_in = (closes_ff != 2'd0) ? EX_PAD : EX_END;
            end
         end
         EX_PAD: begin
            emit_en = 1'b1;
            emit_r  = '{write_valid: 1'b1, write_is_word: 1'b0, write_addr: cursor_ff,
                        write_data: '0, last: 1'b0};
            if (byte_full) begin
               err_in      = ST_FULL;
               ex_state_in = EX_END;
            end else begin
               cursor_in   = cur_p1[ADDR_W-1:0];
               lane_in     = lane_nx;
               ex_state_in = (lane_nx == LANE_W'(1)) ? EX_WORD : EX_PAD;
            end
         end
         EX_WORD: begin
            emit_en     = 1'b1;
            emit_r      = '{write_valid: 1'b1, write_is_word: 1'b1, write_addr: base_addr,
                            write_data: cursor_ff - base_addr - DATA_W'(WORD_BYTES),
                            last: 1'b0};
            ssw_in      = cursor_ff[ADDR_W-1:WB_SHIFT];
            nonempty_in = 1'b0;
            closes_in   = closes_ff - 2'd1;
            if (word_full) begin
               err_in      = ST_FULL;
               cursor_in   = ADDR_W'(limit_ff - LIMIT_W'(1));
               ex_state_in = EX_END;
            end else begin
               cursor_in   = cur_p4[ADDR_W-1:0];
               ex_state_in = (closes_ff != 2'd1) ? EX_WORD : EX_END;
            end
         end
         EX_END: begin
            res_push     = 1'b1;
            res_data     = have_pend_ff ? pend_ff : '0;
            res_data.last = 1'b1;
            stat_push    = 1'b1;
            stat_data    = '{status: err_ff, finished: fin_final};
            finished_in  = fin_final;
            fin_pend_in  = 1'b0;
            have_pend_in = 1'b0;
            ex_state_in  = EX_IDLE;
         end
         default: ex_state_in = EX_IDLE;
      endcase

      // hold one write back so the last one of an item can be marked
      if (emit_en) begin
         res_push     = have_pend_ff;
         res_data     = pend_ff;
         pend_in      = emit_r;
         have_pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_state_ff  <= EX_IDLE;
         ps_ff        <= PS_START;
         cursor_ff    <= ADDR_W'(WORD_BYTES);
         limit_ff     <= LIMIT_W'(MAX_ARENA_WORDS * WORD_BYTES);
         ssw_ff       <= '0;
         lane_ff      <= LANE_W'(1);
         nonempty_ff  <= 1'b0;
         finished_ff  <= 1'b0;
         err_ff       <= ST_OK;
         closes_ff    <= 2'd0;
         fin_pend_ff  <= 1'b0;
         have_pend_ff <= 1'b0;
      end else begin
         ex_state_ff  <= ex_state_in;
         ps_ff        <= ps_in;
         cursor_ff    <= cursor_in;
         limit_ff     <= limit_in;
         ssw_ff       <= ssw_in;
         lane_ff      <= lane_in;
         nonempty_ff  <= nonempty_in;
         finished_ff  <= finished_in;
         err_ff       <= err_in;
         closes_ff    <= closes_in;
         fin_pend_ff  <= fin_pend_in;
         have_pend_ff <= have_pend_in;
      end
   end

   // payload holding registers
   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      pend_ff <= pend_in;
   end

endmodule

FILE: rtl/kvla_rspq.sv
// result queue: holds writes until their item is complete
`timescale 1ns / 1ps

module kvla_rspq import kvla_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          res_push,
   input  result_type    res_data,
   input  logic          stat_push,
   input  item_stat_type stat_data,
   output logic          room,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output result_type    head,
   output item_stat_type head_stat
);

   result_type         mem_ff [RSPQ_DEPTH];
   item_stat_type      stat_mem_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W:0] wr_ff, wr_in;
   logic [RSPQ_PTR_W:0] rd_ff, rd_in;
   logic [RSPQ_PTR_W:0] commit_ff, commit_in;
   logic [RSPQ_PTR_W:0] swr_ff, swr_in;
   logic [RSPQ_PTR_W:0] srd_ff, srd_in;
   logic [RSPQ_PTR_W:0] used;
   logic                pop_ok;

   // only finished items are visible
   assign rsp_empty = (rd_ff == commit_ff);
   assign head      = mem_ff[rd_ff[RSPQ_PTR_W-1:0]];
   assign head_stat = stat_mem_ff[srd_ff[RSPQ_PTR_W-1:0]];
   assign pop_ok    = rsp_pop && !rsp_empty;
   assign used      = wr_ff - rd_ff;
   assign room      = (used <= (RSPQ_PTR_W + 1)'(RSPQ_DEPTH - MAX_RESULTS));

   always_comb begin
      wr_in     = res_push ? wr_ff + 1'b1 : wr_ff;
      commit_in = (res_push && res_data.last) ? wr_ff + 1'b1 : commit_ff;
      rd_in     = pop_ok ? rd_ff + 1'b1 : rd_ff;
      swr_in    = stat_push ? swr_ff + 1'b1 : swr_ff;
      srd_in    = (pop_ok && head.last) ? srd_ff + 1'b1 : srd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff     <= '0;
         rd_ff     <= '0;
         commit_ff <= '0;
         swr_ff    <= '0;
         srd_ff    <= '0;
      end else begin
         wr_ff     <= wr_in;
         rd_ff     <= rd_in;
         commit_ff <= commit_in;
         swr_ff    <= swr_in;
         srd_ff    <= srd_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (res_push) begin
         mem_ff[wr_ff[RSPQ_PTR_W-1:0]] <= res_data;
      end
      if (stat_push) begin
         stat_mem_ff[swr_ff[RSPQ_PTR_W-1:0]] <= stat_data;
      end
   end

endmodule

FILE: rtl/key_value_line_to_arena.sv
// top level of the key/value command line parser that packs strings into an arena
`timescale 1ns / 1ps

// Parses one command line, one byte per input item, into length-prefixed,
// word-padded strings and reports each arena write as one result item; the
// item that closes a string issues a burst of padding byte writes and the
// length word. A small input queue classifies bytes and a sequencer handles
// one item at a time, one arena write per cycle. The sequencer takes an item
// only when the 32-entry result queue has room for sixteen results. Results
// of an item appear together once the item is complete, so status and
// finished show the state after the item. The arena size register is
// sampled at each start item.

module key_value_line_to_arena import kvla_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [1:0]        req_opcode,
   input  logic [7:0]        req_char_byte,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_write_valid,
   output logic              rsp_write_is_word,
   output logic [ADDR_W-1:0] rsp_write_addr,
   output logic [DATA_W-1:0] rsp_write_data,
   output logic [1:0]        rsp_status,
   output logic              rsp_finished,
   output logic              rsp_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CFG_W-1:0]  csr_arena_words
);

   logic [CFG_W-1:0] arena_words_ff, arena_words_in;
   item_type         item;
   logic             item_valid, item_take, room;
   logic             res_push, stat_push;
   result_type       res_data, head;
   item_stat_type    stat_data, head_stat;

   // arena size register
   assign csr_ready      = 1'b1;
   assign arena_words_in = (csr_valid && csr_ready) ? csr_arena_words : arena_words_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_words_ff <= CFG_W'(MAX_ARENA_WORDS);
      end else begin
         arena_words_ff <= arena_words_in;
      end
   end

   kvla_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_opcode    (req_opcode),
      .req_char_byte (req_char_byte),
      .req_full      (req_full),
      .item          (item),
      .item_valid    (item_valid),
      .item_take     (item_take)
   );

   kvla_exec u_exec (
      .clock       (clock),
      .reset       (reset),
      .item        (item),
      .item_valid  (item_valid),
      .item_take   (item_take),
      .room        (room),
      .arena_words (arena_words_ff),
      .res_push    (res_push),
      .res_data    (res_data),
      .stat_push   (stat_push),
      .stat_data   (stat_data)
   );

   kvla_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .res_push  (res_push),
      .res_data  (res_data),
      .stat_push (stat_push),
      .stat_data (stat_data),
      .room      (room),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .head      (head),
      .head_stat (head_stat)
   );

   // result ports
   assign rsp_write_valid   = head.write_valid;
   assign rsp_write_is_word = head.write_is_word;
   assign rsp_write_addr    = head.write_addr;
   assign rsp_write_data    = head.write_data;
   assign rsp_last          = head.last;
   assign rsp_status        = head_stat.status;
   assign rsp_finished      = head_stat.finished;

   // an item is started only with room for all of its results
   a_take_room: assert property (@(posedge clock) disable iff (reset)
      item_take |-> room)
      else $error("item started without result queue room");

   // length words land on word boundaries
   a_word_aligned: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_write_is_word) |-> (rsp_write_valid && rsp_write_addr[1:0] == 2'b00))
      else $error("misaligned length word");

   // a result without a write is the only result of its item
   a_null_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_write_valid) |-> (rsp_last && !rsp_write_is_word))
      else $error("empty result not alone");

   // every item status record is pushed together with its last result
   a_stat_with_last: assert property (@(posedge clock) disable iff (reset)
      stat_push |-> (res_push && res_data.last))
      else $error("status pushed without last result");

endmodule
